// File: design/dda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, command codes and setup types for the line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS = 10;
    localparam int COLOR_BITS = 24;

    // Stream payload widths, padded up to whole bytes.
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   coord_ext_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic   neg;
        coord_t mag;
    } axis_setup_t;

    typedef struct packed
    {
        axis_setup_t x;
        axis_setup_t y;
        coord_t      len;
    } line_setup_t;

endpackage

// File: design/dda_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line setup
// Finds direction and magnitude of each axis difference and the line length.
// ----------------------------------------------------------------------------
module dda_setup
(
    input  dda_pkg::coord_t      x_start,
    input  dda_pkg::coord_t      x_end,
    input  dda_pkg::coord_t      y_start,
    input  dda_pkg::coord_t      y_end,
    output dda_pkg::line_setup_t setup
);

    always_comb
    begin
        setup.x.neg = (x_end < x_start);
        setup.y.neg = (y_end < y_start);
        setup.x.mag = setup.x.neg ? (x_start - x_end) : (x_end - x_start);
        setup.y.mag = setup.y.neg ? (y_start - y_end) : (y_end - y_start);
        setup.len   = (setup.x.mag > setup.y.mag) ? setup.x.mag : setup.y.mag;
    end

endmodule

// File: design/dda_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA axis stepper
// Advances one axis by one line step, zero or one pixel, using quotient and remainder tracking.
// ----------------------------------------------------------------------------
module dda_axis
(
    input  dda_pkg::coord_t      base,
    input  dda_pkg::axis_setup_t axis,
    input  dda_pkg::coord_t      len,
    input  dda_pkg::coord_t      rem,
    input  dda_pkg::coord_t      offset,
    output dda_pkg::coord_t      rem_next,
    output dda_pkg::coord_t      offset_next,
    output dda_pkg::coord_t      coord
);

    dda_pkg::coord_ext_t sum;
    dda_pkg::coord_ext_t reduced;
    logic                wrap;

    always_comb
    begin
        sum     = {1'b0, rem} + {1'b0, axis.mag};
        wrap    = (sum >= {1'b0, len});
        reduced = sum - {1'b0, len};
        rem_next    = wrap ? reduced[dda_pkg::COORD_BITS-1:0] : sum[dda_pkg::COORD_BITS-1:0];
        offset_next = offset + dda_pkg::coord_t'(wrap);
        // Going in the negative direction, a nonzero remainder means the exact
        // position lies below base minus the quotient, so the pixel taken is one further down.
        if (axis.neg)
        begin
            coord = base - offset_next - dda_pkg::coord_t'(rem_next != '0);
        end
        else
        begin
            coord = base + offset_next;
        end
    end

endmodule

// File: design/dda_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Streams the pixels of straight lines, one pixel per start or step command.
// ----------------------------------------------------------------------------
// A start beat (tuser = 0) loads both endpoints and yields the first pixel; each
// step beat (tuser = 1) then yields the next pixel until max(|dx|,|dy|) steps
// are done, the final pixel marked with tlast. A step with no line in progress
// yields nothing, and a zero-length line yields a single pixel with tlast set.
// The block takes one beat per clock and delivers one pixel per clock while
// m_axis_tready holds high: each step is one add and compare per axis between
// the input register and the output register, which a beat passes through in
// that order. Every pixel carries the color last written on the configuration port.
module dda_line_rasterizer
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_start, x_end, y_start, y_end from the lowest bit up.
    input  logic [dda_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // cmd: 0 starts a line, 1 steps one pixel.
    input  logic                               s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixel_x, pixel_y, pixel_value from the lowest bit up, zero padded.
    output logic [dda_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                               m_axis_tlast,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  dda_pkg::color_t                    cfg_data
);

    localparam int CB = dda_pkg::COORD_BITS;

    // Input register.
    logic                 in_valid_reg, in_valid_next;
    dda_pkg::cmd_t        in_cmd_reg, in_cmd_next;
    dda_pkg::coord_t      in_x1_reg, in_x1_next, in_x2_reg, in_x2_next;
    dda_pkg::coord_t      in_y1_reg, in_y1_next, in_y2_reg, in_y2_next;

    // Line state.
    logic                 line_active_reg, line_active_next;
    dda_pkg::coord_t      start_x_reg, start_x_next, start_y_reg, start_y_next;
    dda_pkg::axis_setup_t axis_x_reg, axis_x_next, axis_y_reg, axis_y_next;
    dda_pkg::coord_t      line_len_reg, line_len_next;
    dda_pkg::coord_t      rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    dda_pkg::coord_t      offset_x_reg, offset_x_next, offset_y_reg, offset_y_next;
    dda_pkg::coord_t      steps_left_reg, steps_left_next;
    dda_pkg::color_t      color_reg, color_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    dda_pkg::coord_t      out_x_reg, out_x_next, out_y_reg, out_y_next;
    dda_pkg::color_t      out_color_reg, out_color_next;
    logic                 out_last_reg, out_last_next;

    dda_pkg::line_setup_t setup;
    dda_pkg::coord_t      step_rem_x, step_off_x, step_coord_x;
    dda_pkg::coord_t      step_rem_y, step_off_y, step_coord_y;

    logic                 is_start;
    logic                 produces;
    logic                 out_free;
    logic                 advance;

    dda_setup u_setup
    (
        .x_start (in_x1_reg),
        .x_end   (in_x2_reg),
        .y_start (in_y1_reg),
        .y_end   (in_y2_reg),
        .setup   (setup)
    );

    dda_axis u_axis_x
    (
        .base        (start_x_reg),
        .axis        (axis_x_reg),
        .len         (line_len_reg),
        .rem         (rem_x_reg),
        .offset      (offset_x_reg),
        .rem_next    (step_rem_x),
        .offset_next (step_off_x),
        .coord       (step_coord_x)
    );

    dda_axis u_axis_y
    (
        .base        (start_y_reg),
        .axis        (axis_y_reg),
        .len         (line_len_reg),
        .rem         (rem_y_reg),
        .offset      (offset_y_reg),
        .rem_next    (step_rem_y),
        .offset_next (step_off_y),
        .coord       (step_coord_y)
    );

    assign is_start = (in_cmd_reg == dda_pkg::CMD_START);
    assign produces = is_start || line_active_reg;
    assign out_free = !out_valid_reg || m_axis_tready;
    // A step with no line in progress drops out even while the output is held.
    assign advance  = in_valid_reg && (out_free || !produces);

    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = dda_pkg::OUT_DATA_BITS'({out_color_reg, out_y_reg, out_x_reg});

    always_comb
    begin
        in_valid_next    = in_valid_reg;
        in_cmd_next      = in_cmd_reg;
        in_x1_next       = in_x1_reg;
        in_x2_next       = in_x2_reg;
        in_y1_next       = in_y1_reg;
        in_y2_next       = in_y2_reg;
        line_active_next = line_active_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        axis_x_next      = axis_x_reg;
        axis_y_next      = axis_y_reg;
        line_len_next    = line_len_reg;
        rem_x_next       = rem_x_reg;
        rem_y_next       = rem_y_reg;
        offset_x_next    = offset_x_reg;
        offset_y_next    = offset_y_reg;
        steps_left_next  = steps_left_reg;
        color_next       = color_reg;
        out_valid_next   = out_valid_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_color_next   = out_color_reg;
        out_last_next    = out_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            color_next = cfg_data;
        end

        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
            in_cmd_next   = dda_pkg::cmd_t'(s_axis_tuser);
            in_x1_next    = s_axis_tdata[CB-1:0];
            in_x2_next    = s_axis_tdata[2*CB-1:CB];
            in_y1_next    = s_axis_tdata[3*CB-1:2*CB];
            in_y2_next    = s_axis_tdata[4*CB-1:3*CB];
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance && produces)
        begin
            out_valid_next = 1'b1;
            out_color_next = color_reg;
            if (is_start)
            begin
                start_x_next     = in_x1_reg;
                start_y_next     = in_y1_reg;
                axis_x_next      = setup.x;
                axis_y_next      = setup.y;
                line_len_next    = setup.len;
                rem_x_next       = '0;
                rem_y_next       = '0;
                offset_x_next    = '0;
                offset_y_next    = '0;
                steps_left_next  = setup.len;
                line_active_next = (setup.len != '0);
                out_x_next       = in_x1_reg;
                out_y_next       = in_y1_reg;
                out_last_next    = (setup.len == '0);
            end
            else
            begin
                rem_x_next       = step_rem_x;
                rem_y_next       = step_rem_y;
                offset_x_next    = step_off_x;
                offset_y_next    = step_off_y;
                steps_left_next  = steps_left_reg - dda_pkg::coord_t'(1);
                line_active_next = (steps_left_reg != dda_pkg::coord_t'(1));
                out_x_next       = step_coord_x;
                out_y_next       = step_coord_y;
                out_last_next    = (steps_left_reg == dda_pkg::coord_t'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_cmd_reg      <= dda_pkg::CMD_START;
            in_x1_reg       <= '0;
            in_x2_reg       <= '0;
            in_y1_reg       <= '0;
            in_y2_reg       <= '0;
            line_active_reg <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            axis_x_reg      <= '0;
            axis_y_reg      <= '0;
            line_len_reg    <= '0;
            rem_x_reg       <= '0;
            rem_y_reg       <= '0;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            steps_left_reg  <= '0;
            color_reg       <= dda_pkg::COLOR_RESET;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_color_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            in_cmd_reg      <= in_cmd_next;
            in_x1_reg       <= in_x1_next;
            in_x2_reg       <= in_x2_next;
            in_y1_reg       <= in_y1_next;
            in_y2_reg       <= in_y2_next;
            line_active_reg <= line_active_next;
            start_x_reg     <= start_x_next;
            start_y_reg     <= start_y_next;
            axis_x_reg      <= axis_x_next;
            axis_y_reg      <= axis_y_next;
            line_len_reg    <= line_len_next;
            rem_x_reg       <= rem_x_next;
            rem_y_reg       <= rem_y_next;
            offset_x_reg    <= offset_x_next;
            offset_y_reg    <= offset_y_next;
            steps_left_reg  <= steps_left_next;
            color_reg       <= color_next;
            out_valid_reg   <= out_valid_next;
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_color_reg   <= out_color_next;
            out_last_reg    <= out_last_next;
        end
    end

    // An active line always has steps left, never more than its length.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (steps_left_reg != '0) && (steps_left_reg <= line_len_reg))
        else $error("steps_left out of range while a line is active");

    // Remainders stay below the line length while stepping.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (rem_x_reg < line_len_reg) && (rem_y_reg < line_len_reg))
        else $error("axis remainder not below line length");

    // A finished line lands exactly on its end point, so both remainders are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !line_active_reg |-> (rem_x_reg == '0) && (rem_y_reg == '0))
        else $error("nonzero remainder with no line in progress");

    // The last pixel of a stepped line ends the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_start && line_active_reg && (steps_left_reg == dda_pkg::coord_t'(1)))
        |=> !line_active_reg && out_last_reg)
        else $error("final step did not close the line");

endmodule
